[rtl/ubx_pkg.sv]
// Shared types and constants for the frame receiver.
package ubx_pkg;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Sync pair and framing constants
  localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND    = 8'h62;
  localparam logic [15:0] MIN_NAV_LENGTH = 16'd56;

  // Payload offsets of the captured words
  localparam logic [15:0] LON_OFFSET = 16'd24;
  localparam logic [15:0] LAT_OFFSET = 16'd28;
  localparam logic [15:0] LAT_END    = 16'd32;
  localparam logic [15:0] VN_OFFSET  = 16'd48;
  localparam logic [15:0] VE_OFFSET  = 16'd52;
  localparam logic [15:0] VE_END     = 16'd56;

  // Capture slots
  localparam logic [1:0] SLOT_LON = 2'd0;
  localparam logic [1:0] SLOT_LAT = 2'd1;
  localparam logic [1:0] SLOT_VN  = 2'd2;
  localparam logic [1:0] SLOT_VE  = 2'd3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_STALE_LIMIT = 2'd0,
    CFG_NAV_CLASS   = 2'd1,
    CFG_NAV_ID      = 2'd2
  } cfg_index_t;

  localparam logic [31:0] STALE_LIMIT_RESET = 32'd2000000;
  localparam logic [7:0]  NAV_CLASS_RESET   = 8'd1;
  localparam logic [7:0]  NAV_ID_RESET      = 8'd7;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_OTHER   = 2'd2,
    ST_STALE   = 2'd3
  } status_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CLASS,
    PH_IDENT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } phase_t;

  // Frame completion report from the parser
  typedef struct packed {
    logic        done;
    logic        good;
    logic        sum_ok;
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [15:0] length;
  } frame_info_t;

  // Navigation fix words
  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [31:0] lat;
    logic signed [31:0] vn;
    logic signed [31:0] ve;
  } fix_t;

  // Controls for the age counter
  typedef struct packed {
    logic tick;
    logic clear;
  } age_ctl_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [15:0] length;
    fix_t        fix;
  } result_t;

endpackage

[rtl/ubx_parser.sv]
// Frame parser: sync hunt, header, checksum and fix word capture.
module ubx_parser
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_en,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  nav_class,
  input  logic [7:0]  nav_id,
  output frame_info_t frame,
  output fix_t        fix
);

  phase_t           phase, phase_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic [7:0]       frame_class, frame_class_next;
  logic [7:0]       frame_ident, frame_ident_next;
  logic [15:0]      frame_length, frame_length_next;
  logic [15:0]      byte_index, byte_index_next;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic [7:0]       check_a, check_a_next;
  logic [3:0][31:0] capture_words, capture_words_next;
  logic [3:0][31:0] held_fix, held_fix_next;

  logic        sync_hit;
  logic        payload_last;
  logic [15:0] length_full;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic        cap_hit;
  logic [1:0]  cap_slot;
  logic        sum_ok;
  logic        nav_match;

  assign sync_hit     = (previous_byte == SYNC_FIRST) && (rx_byte == SYNC_SECOND);
  assign payload_last = ({1'b0, byte_index} + 17'd1) >= {1'b0, frame_length};
  assign length_full  = {rx_byte, frame_length[7:0]};
  assign sum_a_add    = sum_a + rx_byte;
  assign sum_b_add    = sum_b + sum_a_add;
  assign sum_ok       = (check_a == sum_a) && (rx_byte == sum_b);
  assign nav_match    = (frame_class == nav_class) && (frame_ident == nav_id) &&
                        (frame_length >= MIN_NAV_LENGTH);

  // Map the payload offset to a capture slot
  always_comb begin
    cap_hit  = 1'b0;
    cap_slot = SLOT_LON;
    if (byte_index >= LON_OFFSET && byte_index < LAT_END) begin
      cap_hit  = 1'b1;
      cap_slot = (byte_index < LAT_OFFSET) ? SLOT_LON : SLOT_LAT;
    end else if (byte_index >= VN_OFFSET && byte_index < VE_END) begin
      cap_hit  = 1'b1;
      cap_slot = (byte_index < VE_OFFSET) ? SLOT_VN : SLOT_VE;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (byte_en) begin
      unique case (phase)
        PH_HUNT:    phase_next = sync_hit ? PH_CLASS : PH_HUNT;
        PH_CLASS:   phase_next = PH_IDENT;
        PH_IDENT:   phase_next = PH_LEN_LO;
        PH_LEN_LO:  phase_next = PH_LEN_HI;
        PH_LEN_HI:  phase_next = (length_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        PH_PAYLOAD: phase_next = payload_last ? PH_CK_A : PH_PAYLOAD;
        PH_CK_A:    phase_next = PH_CK_B;
        PH_CK_B:    phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  // Per-phase datapath updates and frame report
  always_comb begin
    previous_byte_next = previous_byte;
    frame_class_next   = frame_class;
    frame_ident_next   = frame_ident;
    frame_length_next  = frame_length;
    byte_index_next    = byte_index;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    check_a_next       = check_a;
    capture_words_next = capture_words;
    held_fix_next      = held_fix;
    frame              = '0;
    frame.cls          = frame_class;
    frame.ident        = frame_ident;
    frame.length       = frame_length;
    frame.sum_ok       = sum_ok;
    frame.good         = sum_ok && nav_match;
    if (byte_en) begin
      unique case (phase)
        PH_HUNT: begin
          if (sync_hit) begin
            previous_byte_next = 8'd0;
            sum_a_next         = 8'd0;
            sum_b_next         = 8'd0;
            byte_index_next    = 16'd0;
            capture_words_next = '0;
          end else begin
            previous_byte_next = rx_byte;
          end
        end
        PH_CLASS: begin
          frame_class_next = rx_byte;
          sum_a_next       = sum_a_add;
          sum_b_next       = sum_b_add;
        end
        PH_IDENT: begin
          frame_ident_next = rx_byte;
          sum_a_next       = sum_a_add;
          sum_b_next       = sum_b_add;
        end
        PH_LEN_LO: begin
          frame_length_next = {8'd0, rx_byte};
          sum_a_next        = sum_a_add;
          sum_b_next        = sum_b_add;
        end
        PH_LEN_HI: begin
          frame_length_next = length_full;
          sum_a_next        = sum_a_add;
          sum_b_next        = sum_b_add;
          byte_index_next   = 16'd0;
        end
        PH_PAYLOAD: begin
          sum_a_next = sum_a_add;
          sum_b_next = sum_b_add;
          if (cap_hit) begin
            unique case (byte_index[1:0])
              2'd0: capture_words_next[cap_slot][7:0]   = capture_words[cap_slot][7:0] | rx_byte;
              2'd1: capture_words_next[cap_slot][15:8]  = capture_words[cap_slot][15:8] | rx_byte;
              2'd2: capture_words_next[cap_slot][23:16] = capture_words[cap_slot][23:16] | rx_byte;
              2'd3: capture_words_next[cap_slot][31:24] = capture_words[cap_slot][31:24] | rx_byte;
              default: ;
            endcase
          end
          if (!payload_last) begin
            byte_index_next = byte_index + 16'd1;
          end
        end
        PH_CK_A: begin
          check_a_next = rx_byte;
        end
        PH_CK_B: begin
          previous_byte_next = 8'd0;
          frame.done         = 1'b1;
          if (sum_ok && nav_match) begin
            held_fix_next = capture_words;
          end
        end
        default: ;
      endcase
    end
  end

  // Report the fix as it stands after this item
  assign fix.lon = held_fix_next[SLOT_LON];
  assign fix.lat = held_fix_next[SLOT_LAT];
  assign fix.vn  = held_fix_next[SLOT_VN];
  assign fix.ve  = held_fix_next[SLOT_VE];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      previous_byte <= 8'd0;
      frame_class   <= 8'd0;
      frame_ident   <= 8'd0;
      frame_length  <= 16'd0;
      byte_index    <= 16'd0;
      sum_a         <= 8'd0;
      sum_b         <= 8'd0;
      check_a       <= 8'd0;
      capture_words <= '0;
      held_fix      <= '0;
    end else begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      frame_class   <= frame_class_next;
      frame_ident   <= frame_ident_next;
      frame_length  <= frame_length_next;
      byte_index    <= byte_index_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
      check_a       <= check_a_next;
      capture_words <= capture_words_next;
      held_fix      <= held_fix_next;
    end
  end

endmodule

[rtl/ubx_age.sv]
// Saturating age counter with one-shot stale report.
module ubx_age
  import ubx_pkg::*;
#(
  parameter int AGE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  age_ctl_t    ctl,
  input  logic [31:0] stale_limit,
  output logic        stale_now,
  output logic        stale_report
);

  localparam int CMP_BITS = (AGE_BITS > 32) ? AGE_BITS : 32;

  logic [AGE_BITS-1:0] age_ticks, age_ticks_next;
  logic                stale_reported, stale_reported_next;
  logic [AGE_BITS-1:0] age_inc;
  logic [CMP_BITS-1:0] limit_ext;

  assign limit_ext = CMP_BITS'(stale_limit);
  assign age_inc   = (&age_ticks) ? age_ticks : age_ticks + AGE_BITS'(1);
  assign stale_now = CMP_BITS'(age_ticks) > limit_ext;

  // Count ticks, clear on a good fix
  always_comb begin
    age_ticks_next      = age_ticks;
    stale_reported_next = stale_reported;
    stale_report        = 1'b0;
    if (ctl.clear) begin
      age_ticks_next      = '0;
      stale_reported_next = 1'b0;
    end else if (ctl.tick) begin
      age_ticks_next = age_inc;
      if ((CMP_BITS'(age_inc) > limit_ext) && !stale_reported) begin
        stale_report        = 1'b1;
        stale_reported_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_ticks      <= '0;
      stale_reported <= 1'b0;
    end else begin
      age_ticks      <= age_ticks_next;
      stale_reported <= stale_reported_next;
    end
  end

endmodule

[rtl/ubx_out_buf.sv]
// Two-entry result buffer between the parser and the output channel.
module ubx_out_buf
  import ubx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output result_t head
);

  result_t    entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Store the result item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/ubx_frame_receiver.sv]
// Top level of the frame receiver: config registers, parser, age counter, result buffer.
//
// Takes one item per clock cycle while in_stall is low, either a received
// byte or a time tick, and finishes its work in that cycle; a result item is
// written into a two-entry output buffer, so the input keeps flowing while one
// result waits. in_stall rises only when both buffer entries are held.
// Each frame's checksum bytes give one result (ok, bad checksum, other
// message or stale); a tick gives a stale result once when the age first
// passes stale_limit. The held fix is updated only by a good navigation
// frame of at least 56 payload bytes. cfg_ready is always high.
module ubx_frame_receiver
  import ubx_pkg::*;
#(
  parameter int AGE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [7:0]         msg_class,
  output logic [7:0]         msg_ident,
  output logic [15:0]        payload_length,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic signed [31:0] north_velocity,
  output logic signed [31:0] east_velocity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] stale_limit;
  logic [7:0]  nav_class;
  logic [7:0]  nav_id;

  logic        accept;
  logic        byte_en;
  frame_info_t frame;
  fix_t        fix;
  age_ctl_t    age_ctl;
  logic        stale_now;
  logic        stale_report;
  logic        push;
  result_t     result;
  result_t     head;
  logic        buf_full;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_LIMIT_RESET;
      nav_class   <= NAV_CLASS_RESET;
      nav_id      <= NAV_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STALE_LIMIT: stale_limit <= cfg_data;
        CFG_NAV_CLASS:   nav_class   <= cfg_data[7:0];
        CFG_NAV_ID:      nav_id      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;
  assign byte_en  = accept && (operation == OP_BYTE);

  ubx_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .rx_byte   (rx_byte),
    .nav_class (nav_class),
    .nav_id    (nav_id),
    .frame     (frame),
    .fix       (fix)
  );

  assign age_ctl.tick  = accept && (operation == OP_TICK);
  assign age_ctl.clear = frame.done && frame.good;

  ubx_age #(
    .AGE_BITS (AGE_BITS)
  ) u_age (
    .clk          (clk),
    .rst          (rst),
    .ctl          (age_ctl),
    .stale_limit  (stale_limit),
    .stale_now    (stale_now),
    .stale_report (stale_report)
  );

  // Build the result item; stale wins over the frame errors
  always_comb begin
    result     = '0;
    result.fix = fix;
    if (frame.done) begin
      result.cls    = frame.cls;
      result.ident  = frame.ident;
      result.length = frame.length;
      if (frame.good) begin
        result.status = ST_OK;
      end else if (stale_now) begin
        result.status = ST_STALE;
      end else if (!frame.sum_ok) begin
        result.status = ST_BAD_SUM;
      end else begin
        result.status = ST_OTHER;
      end
    end else begin
      result.status = ST_STALE;
    end
  end

  assign push = frame.done || stale_report;

  ubx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (out_valid && !out_stall),
    .full      (buf_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign status         = head.status;
  assign msg_class      = head.cls;
  assign msg_ident      = head.ident;
  assign payload_length = head.length;
  assign latitude       = head.fix.lat;
  assign longitude      = head.fix.lon;
  assign north_velocity = head.fix.vn;
  assign east_velocity  = head.fix.ve;

endmodule

[rtl/ubx_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
module ubx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] payload_length
);

  // Input stalls only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // Hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_length))
    else $error("stalled result changed");

  // Drop everything on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

endmodule

bind ubx_frame_receiver ubx_checker u_ubx_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .payload_length (payload_length)
);
